// ===== rtl/tcpd_pkg.sv =====
// Shared types and constants of the trie common-prefix depth unit.
package tcpd_pkg;

    localparam int MAX_NODES_DEF = 4096;
    localparam int ALPHABET_DEF  = 26;
    localparam int LEVELS_DEF    = 12;

    localparam int ID_FIELD_W     = 12;
    localparam int LETTER_FIELD_W = 5;
    localparam int STATUS_W       = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_I_RDP,
        S_I_RDC,
        S_I_CHK,
        S_I_VER,
        S_I_FILL,
        S_I_FW,
        S_Q_RA,
        S_Q_RB,
        S_Q_DU,
        S_Q_DV,
        S_Q_SW,
        S_Q_L1A,
        S_Q_L1B,
        S_Q_L1C,
        S_Q_EQ,
        S_Q_L2A,
        S_Q_L2B,
        S_Q_L2C,
        S_Q_FIN,
        S_Q_FD,
        S_Q_FE,
        S_DONE
    } tcpd_state_t;

    // Address width of a memory with the given number of entries.
    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== rtl/tcpd_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
module tcpd_ram
    import tcpd_pkg::*;
#(
    parameter int DEPTH = MAX_NODES_DEF,
    parameter int WIDTH = ID_FIELD_W
)
(
    input  logic                        clk,
    input  logic                        we,
    input  logic [addr_bits(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]            wdata,
    input  logic [addr_bits(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/trie_common_prefix_depth_unit.sv =====
// Trie common-prefix depth unit: insert strings, answer longest-common-prefix queries.
//
// Each request is either an insert (parent id plus letter, creating id last+1) or a
// query (two ids, answering the depth of their lowest common ancestor by binary
// lifting). The unit takes one request at a time. An insert that creates a node fills
// its ancestor row level by level; an insert of a string that already exists ends after
// the child check; a query runs two lifting passes; a flagged request goes straight to
// the result. The lifting steps share the single read port of the ancestor and depth
// memories, which the sequencer drives with one address at a time. A finished result
// sits in the output register while the next request is taken. The child table needs
// no clearing pass after reset: a stored child is trusted only if that node is live,
// canonical and records the same parent and letter, so reset takes effect at once.
module trie_common_prefix_depth_unit
    import tcpd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int ALPHABET  = ALPHABET_DEF,
    parameter int LEVELS    = LEVELS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      opcode,
    input  logic [ID_FIELD_W-1:0]     parent_id,
    input  logic [LETTER_FIELD_W-1:0] letter,
    input  logic [ID_FIELD_W-1:0]     node_a,
    input  logic [ID_FIELD_W-1:0]     node_b,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [ID_FIELD_W-1:0]     common_depth,
    output logic [STATUS_W-1:0]       status
);

    localparam int ID_W   = addr_bits(MAX_NODES);
    localparam int LET_W  = addr_bits(ALPHABET);
    localparam int LV_W   = addr_bits(LEVELS);
    localparam int ANC_N  = MAX_NODES * LEVELS;
    localparam int CH_N   = MAX_NODES * ALPHABET;
    localparam int ANC_AW = addr_bits(ANC_N);
    localparam int CH_AW  = addr_bits(CH_N);

    tcpd_state_t state_reg, state_next;

    logic              op_reg, op_next;
    logic [ID_W-1:0]   parent_reg, parent_next;
    logic [LET_W-1:0]  letter_reg, letter_next;
    logic [ID_W-1:0]   a_reg, a_next;
    logic [ID_W-1:0]   b_reg, b_next;
    logic [ID_W-1:0]   last_id_reg, last_id_next;
    logic [ID_W-1:0]   p_reg, p_next;
    logic [ID_W-1:0]   c_reg, c_next;
    logic [ID_W-1:0]   dp_reg, dp_next;
    logic [CH_AW-1:0]  slot_reg, slot_next;
    logic [ID_W-1:0]   u_reg, u_next;
    logic [ID_W-1:0]   v_reg, v_next;
    logic [ID_W-1:0]   du_reg, du_next;
    logic [ID_W-1:0]   dv_reg, dv_next;
    logic [ID_W-1:0]   w_reg, w_next;
    logic [ID_W-1:0]   pu_reg, pu_next;
    logic [LV_W-1:0]   lvl_reg, lvl_next;
    logic [ID_W-1:0]   res_depth_reg, res_depth_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [ID_FIELD_W-1:0] out_depth_reg, out_depth_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    // Memory ports
    logic              canon_we;
    logic [ID_W-1:0]   canon_waddr, canon_wdata, canon_raddr, canon_rdata;
    logic              depth_we;
    logic [ID_W-1:0]   depth_waddr, depth_wdata, depth_raddr, depth_rdata;
    logic              let_we;
    logic [ID_W-1:0]   let_waddr, let_raddr;
    logic [LET_W-1:0]  let_wdata, let_rdata;
    logic              anc_we;
    logic [ANC_AW-1:0] anc_waddr, anc_raddr;
    logic [ID_W-1:0]   anc_wdata, anc_rdata;
    logic              child_we;
    logic [CH_AW-1:0]  child_waddr, child_raddr;
    logic [ID_W-1:0]   child_wdata, child_rdata;

    logic [ID_W-1:0]   p_fresh, w_fresh, val_fresh, dw_fresh, pv_fresh;
    logic              child_match, load_out;

    tcpd_ram #(.DEPTH(MAX_NODES), .WIDTH(ID_W)) u_canon (
        .clk(clk), .we(canon_we), .waddr(canon_waddr), .wdata(canon_wdata),
        .raddr(canon_raddr), .rdata(canon_rdata)
    );

    tcpd_ram #(.DEPTH(MAX_NODES), .WIDTH(ID_W)) u_depth (
        .clk(clk), .we(depth_we), .waddr(depth_waddr), .wdata(depth_wdata),
        .raddr(depth_raddr), .rdata(depth_rdata)
    );

    tcpd_ram #(.DEPTH(MAX_NODES), .WIDTH(LET_W)) u_letter (
        .clk(clk), .we(let_we), .waddr(let_waddr), .wdata(let_wdata),
        .raddr(let_raddr), .rdata(let_rdata)
    );

    tcpd_ram #(.DEPTH(ANC_N), .WIDTH(ID_W)) u_anc (
        .clk(clk), .we(anc_we), .waddr(anc_waddr), .wdata(anc_wdata),
        .raddr(anc_raddr), .rdata(anc_rdata)
    );

    tcpd_ram #(.DEPTH(CH_N), .WIDTH(ID_W)) u_child (
        .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
        .raddr(child_raddr), .rdata(child_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_id_reg   <= '0;
            out_valid_reg <= 1'b0;
            lvl_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            last_id_reg   <= last_id_next;
            out_valid_reg <= out_valid_next;
            lvl_reg       <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        parent_reg     <= parent_next;
        letter_reg     <= letter_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        p_reg          <= p_next;
        c_reg          <= c_next;
        dp_reg         <= dp_next;
        slot_reg       <= slot_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        du_reg         <= du_next;
        dv_reg         <= dv_next;
        w_reg          <= w_next;
        pu_reg         <= pu_next;
        res_depth_reg  <= res_depth_next;
        res_status_reg <= res_status_next;
        out_depth_reg  <= out_depth_next;
        out_status_reg <= out_status_next;
    end

    // Entry 0 of the canon, ancestor and depth stores is the root: read it as zero.
    assign p_fresh   = (parent_reg == '0) ? '0 : canon_rdata;
    assign w_fresh   = (u_reg == '0) ? '0 : anc_rdata;
    assign val_fresh = (w_reg == '0) ? '0 : anc_rdata;
    assign dw_fresh  = (w_reg == '0) ? '0 : depth_rdata;
    assign pv_fresh  = (v_reg == '0) ? '0 : anc_rdata;

    // A stored child counts only if it is a live canonical node with this parent and letter.
    assign child_match = (c_reg != '0) && (c_reg <= last_id_reg) && (canon_rdata == c_reg)
                         && (anc_rdata == p_reg) && (let_rdata == letter_reg);

    assign load_out = (state_reg == S_DONE) && !(out_valid_reg && out_stall);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        parent_next     = parent_reg;
        letter_next     = letter_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        last_id_next    = last_id_reg;
        p_next          = p_reg;
        c_next          = c_reg;
        dp_next         = dp_reg;
        slot_next       = slot_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        du_next         = du_reg;
        dv_next         = dv_reg;
        w_next          = w_reg;
        pu_next         = pu_reg;
        lvl_next        = lvl_reg;
        res_depth_next  = res_depth_reg;
        res_status_next = res_status_reg;
        out_depth_next  = out_depth_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;

        canon_we    = 1'b0;
        canon_waddr = last_id_reg;
        canon_wdata = c_reg;
        canon_raddr = '0;
        depth_we    = 1'b0;
        depth_waddr = last_id_reg;
        depth_wdata = ID_W'(dp_reg + 1'b1);
        depth_raddr = '0;
        let_we      = 1'b0;
        let_waddr   = last_id_reg;
        let_wdata   = letter_reg;
        let_raddr   = '0;
        anc_we      = 1'b0;
        anc_waddr   = ANC_AW'(32'(last_id_reg) * LEVELS);
        anc_wdata   = p_reg;
        anc_raddr   = '0;
        child_we    = 1'b0;
        child_waddr = slot_reg;
        child_wdata = last_id_reg;
        child_raddr = '0;

        in_stall = (state_reg != S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = opcode;
                    parent_next     = ID_W'(parent_id);
                    letter_next     = LET_W'(letter);
                    a_next          = ID_W'(node_a);
                    b_next          = ID_W'(node_b);
                    res_depth_next  = '0;
                    res_status_next = STATUS_OK;
                    if (opcode == OP_INSERT)
                    begin
                        if ((32'(parent_id) > 32'(last_id_reg)) || (32'(letter) >= ALPHABET))
                        begin
                            res_status_next = STATUS_BAD;
                            state_next      = S_DONE;
                        end
                        else if (32'(last_id_reg) + 1 >= MAX_NODES)
                        begin
                            res_status_next = STATUS_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_I_RDP;
                        end
                    end
                    else
                    begin
                        if ((32'(node_a) > 32'(last_id_reg)) || (32'(node_b) > 32'(last_id_reg)))
                        begin
                            res_status_next = STATUS_BAD;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            state_next = S_Q_RA;
                        end
                    end
                end
            end

            S_I_RDP:
            begin
                canon_raddr = parent_reg;
                state_next  = S_I_RDC;
            end

            S_I_RDC:
            begin
                p_next      = p_fresh;
                slot_next   = CH_AW'(32'(p_fresh) * ALPHABET + 32'(letter_reg));
                child_raddr = CH_AW'(32'(p_fresh) * ALPHABET + 32'(letter_reg));
                depth_raddr = p_fresh;
                state_next  = S_I_CHK;
            end

            S_I_CHK:
            begin
                c_next      = child_rdata;
                dp_next     = (p_reg == '0) ? '0 : depth_rdata;
                canon_raddr = child_rdata;
                let_raddr   = child_rdata;
                anc_raddr   = ANC_AW'(32'(child_rdata) * LEVELS);
                state_next  = S_I_VER;
            end

            S_I_VER:
            begin
                last_id_next    = ID_W'(last_id_reg + 1'b1);
                res_depth_next  = ID_W'(last_id_reg + 1'b1);
                canon_we        = 1'b1;
                canon_waddr     = ID_W'(last_id_reg + 1'b1);
                if (child_match)
                begin
                    canon_wdata = c_reg;
                    state_next  = S_DONE;
                end
                else
                begin
                    // Create the node: child link, depth, letter and first ancestor.
                    c_next      = ID_W'(last_id_reg + 1'b1);
                    canon_wdata = ID_W'(last_id_reg + 1'b1);
                    child_we    = 1'b1;
                    child_wdata = ID_W'(last_id_reg + 1'b1);
                    depth_we    = 1'b1;
                    depth_waddr = ID_W'(last_id_reg + 1'b1);
                    let_we      = 1'b1;
                    let_waddr   = ID_W'(last_id_reg + 1'b1);
                    anc_we      = 1'b1;
                    anc_waddr   = ANC_AW'(32'(ID_W'(last_id_reg + 1'b1)) * LEVELS);
                    anc_wdata   = p_reg;
                    w_next      = p_reg;
                    lvl_next    = LV_W'(1);
                    state_next  = (LEVELS > 1) ? S_I_FILL : S_DONE;
                end
            end

            S_I_FILL:
            begin
                anc_raddr  = ANC_AW'(32'(w_reg) * LEVELS + 32'(lvl_reg) - 1);
                state_next = S_I_FW;
            end

            S_I_FW:
            begin
                anc_we    = 1'b1;
                anc_waddr = ANC_AW'(32'(last_id_reg) * LEVELS + 32'(lvl_reg));
                anc_wdata = val_fresh;
                w_next    = val_fresh;
                if (32'(lvl_reg) == LEVELS - 1)
                begin
                    lvl_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next   = LV_W'(lvl_reg + 1'b1);
                    state_next = S_I_FILL;
                end
            end

            S_Q_RA:
            begin
                canon_raddr = a_reg;
                state_next  = S_Q_RB;
            end

            S_Q_RB:
            begin
                u_next      = (a_reg == '0) ? '0 : canon_rdata;
                canon_raddr = b_reg;
                state_next  = S_Q_DU;
            end

            S_Q_DU:
            begin
                v_next      = (b_reg == '0) ? '0 : canon_rdata;
                depth_raddr = u_reg;
                state_next  = S_Q_DV;
            end

            S_Q_DV:
            begin
                du_next     = (u_reg == '0) ? '0 : depth_rdata;
                depth_raddr = v_reg;
                state_next  = S_Q_SW;
            end

            S_Q_SW:
            begin
                // Keep the deeper node in u.
                if (du_reg < ((v_reg == '0) ? '0 : depth_rdata))
                begin
                    u_next  = v_reg;
                    v_next  = u_reg;
                    du_next = (v_reg == '0) ? '0 : depth_rdata;
                    dv_next = du_reg;
                end
                else
                begin
                    dv_next = (v_reg == '0) ? '0 : depth_rdata;
                end
                lvl_next   = LV_W'(LEVELS - 1);
                state_next = S_Q_L1A;
            end

            S_Q_L1A:
            begin
                anc_raddr  = ANC_AW'(32'(u_reg) * LEVELS + 32'(lvl_reg));
                state_next = S_Q_L1B;
            end

            S_Q_L1B:
            begin
                w_next      = w_fresh;
                depth_raddr = w_fresh;
                state_next  = S_Q_L1C;
            end

            S_Q_L1C:
            begin
                if (dw_fresh >= dv_reg)
                begin
                    u_next  = w_reg;
                    du_next = dw_fresh;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_EQ;
                end
                else
                begin
                    lvl_next   = LV_W'(lvl_reg - 1'b1);
                    state_next = S_Q_L1A;
                end
            end

            S_Q_EQ:
            begin
                if (u_reg == v_reg)
                begin
                    res_depth_next = du_reg;
                    state_next     = S_DONE;
                end
                else
                begin
                    lvl_next   = LV_W'(LEVELS - 1);
                    state_next = S_Q_L2A;
                end
            end

            S_Q_L2A:
            begin
                anc_raddr  = ANC_AW'(32'(u_reg) * LEVELS + 32'(lvl_reg));
                state_next = S_Q_L2B;
            end

            S_Q_L2B:
            begin
                pu_next    = w_fresh;
                anc_raddr  = ANC_AW'(32'(v_reg) * LEVELS + 32'(lvl_reg));
                state_next = S_Q_L2C;
            end

            S_Q_L2C:
            begin
                if (pu_reg != pv_fresh)
                begin
                    u_next = pu_reg;
                    v_next = pv_fresh;
                end
                if (lvl_reg == '0)
                begin
                    state_next = S_Q_FIN;
                end
                else
                begin
                    lvl_next   = LV_W'(lvl_reg - 1'b1);
                    state_next = S_Q_L2A;
                end
            end

            S_Q_FIN:
            begin
                anc_raddr  = ANC_AW'(32'(u_reg) * LEVELS);
                state_next = S_Q_FD;
            end

            S_Q_FD:
            begin
                w_next      = w_fresh;
                depth_raddr = w_fresh;
                state_next  = S_Q_FE;
            end

            S_Q_FE:
            begin
                res_depth_next = dw_fresh;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                // Hold until the output register is free.
                if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    out_depth_next  = ID_FIELD_W'(res_depth_reg);
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign common_depth = out_depth_reg;
    assign status       = out_status_reg;

    a_last_id_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(last_id_reg) < MAX_NODES)
        else $error("last_id beyond table");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STATUS_OK)) |-> (common_depth == '0))
        else $error("flagged result carries nonzero depth");

    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(lvl_reg) < LEVELS)
        else $error("level counter out of range");

    a_insert_id: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && (op_reg == OP_INSERT) && (res_status_reg == STATUS_OK))
        |-> (res_depth_reg == last_id_reg))
        else $error("insert result does not match new id");

endmodule

// ===== verif/trie_common_prefix_depth_unit_test.sv =====
// Testbench of the trie common-prefix depth unit: random requests checked against a trie model.
`timescale 1ns / 1ps

module trie_common_prefix_depth_unit_test
    import tcpd_pkg::*;
();

    localparam int NODES  = MAX_NODES_DEF;
    localparam int ALPHA  = ALPHABET_DEF;
    localparam int LIFT   = LEVELS_DEF;

    typedef struct packed {
        logic                      op;
        logic [ID_FIELD_W-1:0]     parent;
        logic [LETTER_FIELD_W-1:0] ltr;
        logic [ID_FIELD_W-1:0]     a;
        logic [ID_FIELD_W-1:0]     b;
    } request_t;

    typedef struct packed {
        logic [ID_FIELD_W-1:0] depth;
        logic [STATUS_W-1:0]   stat;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = OP_INSERT;
    logic [ID_FIELD_W-1:0] parent_id = '0;
    logic [LETTER_FIELD_W-1:0] letter = '0;
    logic [ID_FIELD_W-1:0] node_a = '0;
    logic [ID_FIELD_W-1:0] node_b = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [ID_FIELD_W-1:0] common_depth;
    logic [STATUS_W-1:0] status;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;

    // trie model
    int last_id;
    int canon[NODES];
    int child[NODES][ALPHA];
    int depth_of[NODES];
    int lift_tab[NODES][LIFT];

    always #4 clk = ~clk;

    trie_common_prefix_depth_unit u_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .parent_id(parent_id), .letter(letter),
        .node_a(node_a), .node_b(node_b), .out_valid(out_valid),
        .out_stall(out_stall), .common_depth(common_depth), .status(status)
    );

    function automatic int prefix_len(int ida, int idb);
        int u;
        int v;
        int t;
        int w;
        u = canon[ida];
        v = canon[idb];
        if (depth_of[u] < depth_of[v])
        begin
            t = u; u = v; v = t;
        end
        for (int i = LIFT - 1; i >= 0; i--)
        begin
            w = lift_tab[u][i];
            if (depth_of[w] >= depth_of[v]) u = w;
        end
        if (u == v) return depth_of[u];
        for (int i = LIFT - 1; i >= 0; i--)
        begin
            if (lift_tab[u][i] != lift_tab[v][i])
            begin
                u = lift_tab[u][i];
                v = lift_tab[v][i];
            end
        end
        return depth_of[lift_tab[u][0]];
    endfunction

    function automatic answer_t trie_apply(request_t r);
        answer_t ans;
        int p;
        int c;
        ans = '0;
        if (r.op == OP_INSERT)
        begin
            if (r.parent > last_id || r.ltr >= ALPHA)
                ans.stat = STATUS_BAD;
            else if (last_id + 1 >= NODES)
                ans.stat = STATUS_FULL;
            else
            begin
                p = canon[r.parent];
                c = child[p][r.ltr];
                if (c == 0)
                begin
                    c = last_id + 1;
                    child[p][r.ltr] = c;
                    depth_of[c] = depth_of[p] + 1;
                    lift_tab[c][0] = p;
                    for (int j = 1; j < LIFT; j++)
                        lift_tab[c][j] = lift_tab[lift_tab[c][j-1]][j-1];
                end
                last_id++;
                canon[last_id] = c;
                ans.depth = last_id[ID_FIELD_W-1:0];
            end
        end
        else if (r.a > last_id || r.b > last_id)
            ans.stat = STATUS_BAD;
        else
            ans.depth = ID_FIELD_W'(prefix_len(r.a, r.b));
        return ans;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic queue_req(request_t r);
        pending_reqs = {pending_reqs, r};
    endtask

    // Driver: bursts of requests with random gaps.
    always @(posedge clk)
    begin
        request_t r;
        answer_t  predicted;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = trie_apply(pending_reqs.pop_front());
                expected_answers = {expected_answers, predicted};
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                    in_valid <= 1'b0;
                else
                begin
                    r = pending_reqs[0];
                    in_valid <= 1'b1;
                    opcode <= r.op;
                    parent_id <= r.parent;
                    letter <= r.ltr;
                    node_a <= r.a;
                    node_b <= r.b;
                    if (burst_left > 0) burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
            end
        end
    end

    // Monitor and receiver stall pattern.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("unexpected result", common_depth, -1);
                else
                begin
                    want = expected_answers.pop_front();
                    if (common_depth !== want.depth)
                        report_mismatch("common_depth", common_depth, want.depth);
                    if (status !== want.stat)
                        report_mismatch("status", status, want.stat);
                end
            end
            case ($urandom_range(0, 7))
                0, 1: out_stall <= 1'b1;
                2: out_stall <= ($urandom_range(0, 1) == 1);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    function automatic request_t mk(bit op, int p, int l, int a, int b);
        request_t r;
        r.op = op;
        r.parent = ID_FIELD_W'(p);
        r.ltr = LETTER_FIELD_W'(l);
        r.a = ID_FIELD_W'(a);
        r.b = ID_FIELD_W'(b);
        return r;
    endfunction

    int ids_planned;

    initial
    begin
        int p;
        last_id = 0;
        canon[0] = 0;
        depth_of[0] = 0;
        for (int n = 0; n < NODES; n++)
            for (int l = 0; l < ALPHA; l++) child[n][l] = 0;
        for (int j = 0; j < LIFT; j++) lift_tab[0][j] = 0;

        // Directed: root query, bad ids and letters, chains, duplicate strings.
        queue_req(mk(OP_QUERY, 0, 0, 0, 0));
        queue_req(mk(OP_QUERY, 0, 0, 4095, 0));
        queue_req(mk(OP_QUERY, 0, 0, 0, 1));
        queue_req(mk(OP_INSERT, 1, 0, 0, 0));
        queue_req(mk(OP_INSERT, 4095, 0, 0, 0));
        queue_req(mk(OP_INSERT, 0, 26, 0, 0));
        queue_req(mk(OP_INSERT, 0, 31, 4095, 4095));
        queue_req(mk(OP_INSERT, 0, 0, 4095, 4095));
        queue_req(mk(OP_INSERT, 1, 25, 0, 0));
        queue_req(mk(OP_INSERT, 0, 0, 0, 0));
        queue_req(mk(OP_INSERT, 3, 25, 0, 0));
        queue_req(mk(OP_INSERT, 0, 25, 0, 0));
        queue_req(mk(OP_QUERY, 4095, 31, 2, 4));
        queue_req(mk(OP_QUERY, 0, 0, 2, 3));
        queue_req(mk(OP_QUERY, 0, 0, 4, 5));
        queue_req(mk(OP_QUERY, 0, 0, 1, 1));
        queue_req(mk(OP_QUERY, 0, 0, 5, 6));
        ids_planned = 5;

        // Random: long chains for deep lifting, mostly valid items.
        for (int k = 0; k < 430; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    p = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ids_planned)
                        : ids_planned - $urandom_range(0, 2);
                    if (p < 0) p = 0;
                    queue_req(mk(OP_INSERT, p, $urandom_range(0, 2),
                        $urandom, $urandom));
                    ids_planned++;
                end
                4, 5, 6, 7, 8:
                    queue_req(mk(OP_QUERY, $urandom, $urandom,
                        $urandom_range(0, ids_planned), $urandom_range(0, ids_planned)));
                default:
                    queue_req(mk(($urandom_range(0, 1) == 1), $urandom, $urandom,
                        $urandom, $urandom));
            endcase
        end
        queue_req(mk(OP_QUERY, 0, 0, 4095, 4000));
        queue_req(mk(OP_QUERY, 0, 0, 4095, 1));
        queue_req(mk(OP_INSERT, 0, 25, 0, 0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0);
        wait (expected_answers.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tcpd_pkg.sv
rtl/tcpd_ram.sv
rtl/trie_common_prefix_depth_unit.sv
verif/trie_common_prefix_depth_unit_test.sv
